@@ rtl/spq_pkg.sv @@
// Shared types and codes for the stable priority ready queue.
// No dependencies; imported by spq_ctrl, spq_dp and the top level.
`default_nettype none

package spq_pkg;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Request modes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic execute;   // apply the latched request and load the result
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
// Handshake controller for the stable priority ready queue.
// Depends on spq_pkg; drives commands into spq_dp.
`default_nettype none

module spq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output spq_pkg::cmd_t     cmd
);
  import spq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;
  logic   out_free;

  // Result register can take a new item when empty or being drained
  assign out_free = !out_valid || !out_stall;

  // Accept only while idle; a pending result does not block acceptance
  assign in_stall = (state != S_IDLE);

  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.execute = (state == S_RUN) && out_free;

  // Advance state and hold the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/spq_dp.sv @@
// Datapath of the stable priority ready queue: sorted shift-register cells,
// request latch and result register. Depends on spq_pkg; driven by spq_ctrl.
`default_nettype none

module spq_dp #(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 8,
  parameter int PRIO_BITS = 8,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  spq_pkg::cmd_t             cmd,
  input  wire logic                 mode,
  input  wire logic [ID_BITS-1:0]   task_id,
  input  wire logic [PRIO_BITS-1:0] task_priority,
  output logic [1:0]                status,
  output logic                      taken_valid,
  output logic [ID_BITS-1:0]        taken_task,
  output logic                      head_valid,
  output logic [ID_BITS-1:0]        head_task,
  output logic [PRIO_BITS-1:0]      head_priority,
  output logic [CNT_W-1:0]          entry_count
);
  import spq_pkg::*;

  // Latched request
  logic                 req_mode;
  logic [ID_BITS-1:0]   req_id;
  logic [PRIO_BITS-1:0] req_prio;

  // Queue cells, slot 0 is the head
  logic [ID_BITS-1:0]   slot_task [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio [DEPTH];
  logic [CNT_W-1:0]     count;

  // Per-cell next values for insert and remove
  logic [ID_BITS-1:0]   enq_task [DEPTH];
  logic [PRIO_BITS-1:0] enq_prio [DEPTH];
  logic [ID_BITS-1:0]   deq_task [DEPTH];
  logic [PRIO_BITS-1:0] deq_prio [DEPTH];
  logic [DEPTH-1:0]     ge;
  logic [DEPTH-1:0]     ge_prev;

  logic                 full;
  logic                 empty;
  logic                 do_enq;
  logic                 do_deq;
  logic [CNT_W-1:0]     count_next;
  logic [ID_BITS-1:0]   head_task_next;
  logic [PRIO_BITS-1:0] head_prio_next;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode <= mode;
      req_id   <= task_id;
      req_prio <= task_priority;
    end
  end

  // Mark occupied cells that stay ahead of the new entry
  assign ge_prev = {ge[DEPTH-2:0], 1'b0};

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    assign ge[g] = (CNT_W'(g) < count) && (slot_prio[g] >= req_prio);

    // Insert: keep, take the new entry, or shift down from the cell above
    if (g == 0) begin : g_head
      assign enq_task[g] = ge[g] ? slot_task[g] : req_id;
      assign enq_prio[g] = ge[g] ? slot_prio[g] : req_prio;
    end else begin : g_body
      assign enq_task[g] = ge[g] ? slot_task[g] :
                           (ge_prev[g] ? req_id : slot_task[g-1]);
      assign enq_prio[g] = ge[g] ? slot_prio[g] :
                           (ge_prev[g] ? req_prio : slot_prio[g-1]);
    end

    // Remove: shift up toward the head
    if (g == DEPTH - 1) begin : g_tail
      assign deq_task[g] = slot_task[g];
      assign deq_prio[g] = slot_prio[g];
    end else begin : g_mid
      assign deq_task[g] = slot_task[g+1];
      assign deq_prio[g] = slot_prio[g+1];
    end
  end

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_enq = cmd.execute && (req_mode == MODE_ENQ) && !full;
  assign do_deq = cmd.execute && (req_mode == MODE_DEQ) && !empty;

  // Work out count and head after the request
  always_comb begin
    count_next     = count;
    head_task_next = slot_task[0];
    head_prio_next = slot_prio[0];
    if (do_enq) begin
      count_next     = count + CNT_W'(1);
      head_task_next = enq_task[0];
      head_prio_next = enq_prio[0];
    end else if (do_deq) begin
      count_next     = count - CNT_W'(1);
      head_task_next = deq_task[0];
      head_prio_next = deq_prio[0];
    end
  end

  // Update the cells
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_enq) begin
        slot_task[i] <= enq_task[i];
        slot_prio[i] <= enq_prio[i];
      end else if (do_deq) begin
        slot_task[i] <= deq_task[i];
        slot_prio[i] <= deq_prio[i];
      end
    end
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (req_mode == MODE_ENQ) begin
        status <= full ? ST_FULL : ST_DONE;
      end else begin
        status <= empty ? ST_EMPTY : ST_DONE;
      end
      taken_valid   <= do_deq;
      taken_task    <= do_deq ? slot_task[0] : '0;
      head_valid    <= (count_next != '0);
      head_task     <= (count_next != '0) ? head_task_next : '0;
      head_priority <= (count_next != '0) ? head_prio_next : '0;
      entry_count   <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stable_priority_ready_queue.sv @@
// Stable priority ready queue, top level.
// Requests arrive on the input channel: mode 0 inserts task_id with
// task_priority behind every entry of greater or equal priority, mode 1
// removes the head entry. Larger priorities leave first; equal priorities
// leave in arrival order. Up to DEPTH entries are held; an insert into a
// full queue is dropped with status full, a removal from an empty queue
// returns status empty.
// Every item yields exactly one result item carrying the status, the removed
// task, the head entry and the entry count after the request.
// An item is latched while idle, then applied to all cells in parallel
// once the result register is free, which also loads its result there;
// no new item is taken until then. The compare-and-shift across the
// cell row is the single working step.
// Reset empties the queue; no clearing pass is needed.
// A stalled result is held in the output register; the next item is still
// accepted, and waits in the request latch until the result is taken.
// Depends on spq_pkg, spq_ctrl and spq_dp.
`default_nettype none

module stable_priority_ready_queue #(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 8,
  parameter int PRIO_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         mode,
  input  wire logic [ID_BITS-1:0]           task_id,
  input  wire logic [PRIO_BITS-1:0]         task_priority,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        status,
  output logic                              taken_valid,
  output logic [ID_BITS-1:0]                taken_task,
  output logic                              head_valid,
  output logic [ID_BITS-1:0]                head_task,
  output logic [PRIO_BITS-1:0]              head_priority,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t cmd;

  // Handshake and sequencing
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Sorted cells and result register
  spq_dp #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .mode          (mode),
    .task_id       (task_id),
    .task_priority (task_priority),
    .status        (status),
    .taken_valid   (taken_valid),
    .taken_task    (taken_task),
    .head_valid    (head_valid),
    .head_task     (head_task),
    .head_priority (head_priority),
    .entry_count   (entry_count)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_stable_priority_ready_queue.sv @@
// Self-checking testbench for the stable priority ready queue: random and directed
// enqueue/dequeue traffic with random idling on both channels.
// Depends on spq_pkg and the stable_priority_ready_queue top level.
import spq_pkg::*;

localparam int QUEUE_SLOTS = 16;

typedef struct packed {
  logic [1:0] status;
  logic       taken_valid;
  logic [7:0] taken_task;
  logic       head_valid;
  logic [7:0] head_task;
  logic [7:0] head_priority;
  logic [4:0] entry_count;
} queue_result_t;

// Mirror of the sorted queue plus the results still owed by the block
class ready_queue_scoreboard;
  logic [7:0]    slot_id   [QUEUE_SLOTS];
  logic [7:0]    slot_prio [QUEUE_SLOTS];
  int            count;
  int unsigned   errors;
  queue_result_t awaited_results[$];

  function new();
    count  = 0;
    errors = 0;
  endfunction

  // Apply one accepted request to the mirror and queue its result
  function void note_request(logic req_mode, logic [7:0] id, logic [7:0] prio);
    queue_result_t r;
    int            pos;
    r = '0;
    r.status = ST_DONE;
    if (req_mode == MODE_ENQ) begin
      if (count >= QUEUE_SLOTS) begin
        r.status = ST_FULL;
      end else begin
        // insert behind every entry of greater or equal priority
        pos = 0;
        while (pos < count && slot_prio[pos] >= prio) pos++;
        for (int i = count; i > pos; i--) begin
          slot_id[i]   = slot_id[i-1];
          slot_prio[i] = slot_prio[i-1];
        end
        slot_id[pos]   = id;
        slot_prio[pos] = prio;
        count++;
      end
    end else begin
      if (count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // pop the head and shift the rest up
        r.taken_valid = 1'b1;
        r.taken_task  = slot_id[0];
        for (int i = 0; i + 1 < count; i++) begin
          slot_id[i]   = slot_id[i+1];
          slot_prio[i] = slot_prio[i+1];
        end
        count--;
      end
    end
    if (count > 0) begin
      r.head_valid    = 1'b1;
      r.head_task     = slot_id[0];
      r.head_priority = slot_prio[0];
    end
    r.entry_count = count[4:0];
    awaited_results.push_back(r);
  endfunction

  function void report(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  // Compare one accepted result with the oldest owed result
  function void check_result(queue_result_t got);
    queue_result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      errors++;
      return;
    end
    want = awaited_results.pop_front();
    report("status", want.status, got.status);
    report("taken_valid", want.taken_valid, got.taken_valid);
    report("taken_task", want.taken_task, got.taken_task);
    report("head_valid", want.head_valid, got.head_valid);
    report("head_task", want.head_task, got.head_task);
    report("head_priority", want.head_priority, got.head_priority);
    report("entry_count", want.entry_count, got.entry_count);
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction
endclass

module tb_stable_priority_ready_queue;
  localparam int RANDOM_ITEMS = 530;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       mode;
  logic [7:0] task_id;
  logic [7:0] task_priority;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] status;
  logic       taken_valid;
  logic [7:0] taken_task;
  logic       head_valid;
  logic [7:0] head_task;
  logic [7:0] head_priority;
  logic [4:0] entry_count;

  int unsigned cycle_count = 0;
  bit          sender_quiet = 1'b0;
  bit          receiver_quiet = 1'b0;

  ready_queue_scoreboard sb = new();

  stable_priority_ready_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .task_id(task_id), .task_priority(task_priority),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .taken_valid(taken_valid), .taken_task(taken_task),
    .head_valid(head_valid), .head_task(head_task), .head_priority(head_priority),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Hold off for a random gap, then present one item until it is accepted
  task automatic send_request(logic req_mode, logic [7:0] id, logic [7:0] prio);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= req_mode;
    task_id       <= id;
    task_priority <= prio;
    do @(posedge clk); while (in_stall);
    sb.note_request(req_mode, id, prio);
  endtask

  // Stall the result channel for a random stretch before each result
  initial begin
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    forever begin
      if (taken % 32 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      hold = receiver_quiet ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid || rst);
      taken++;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin : result_monitor
    queue_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status        = status;
      got.taken_valid   = taken_valid;
      got.taken_task    = taken_task;
      got.head_valid    = head_valid;
      got.head_task     = head_task;
      got.head_priority = head_priority;
      got.entry_count   = entry_count;
      sb.check_result(got);
    end
  end

  initial begin
    logic [7:0]  prio_picks [6];
    phase_kind_t kind;
    int unsigned phase_len;
    int unsigned sent;
    int unsigned enq_pct;
    logic        req_mode;
    logic [7:0]  prio;

    prio_picks = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    mode          <= MODE_ENQ;
    task_id       <= '0;
    task_priority <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: dequeue from empty, extremes, ties, fill to full, overflow
    send_request(MODE_DEQ, 8'h00, 8'h00);
    send_request(MODE_ENQ, 8'hFF, 8'h00);
    send_request(MODE_ENQ, 8'h00, 8'hFF);
    send_request(MODE_ENQ, 8'hA5, 8'h00);
    send_request(MODE_ENQ, 8'h5A, 8'hFF);
    for (int k = 0; k < 12; k++) begin
      send_request(MODE_ENQ, 8'(16 + k), 8'((k % 4) * 85));
    end
    send_request(MODE_ENQ, 8'h77, 8'd200);
    repeat (5) send_request(MODE_DEQ, 8'hFF, 8'hFF);

    // Random: phases that lean toward filling, draining or a mix
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len    = $urandom_range(10, 40);
      kind         = phase_kind_t'($urandom_range(0, 2));
      sender_quiet = ($urandom_range(0, 3) == 0);
      case (kind)
        PH_FILL:  enq_pct = 80;
        PH_DRAIN: enq_pct = 20;
        default:  enq_pct = 50;
      endcase
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        req_mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        // favor a few priorities so that ties are common
        if ($urandom_range(0, 1) == 0) prio = prio_picks[$urandom_range(0, 5)];
        else prio = 8'($urandom_range(0, 255));
        send_request(req_mode, 8'($urandom_range(0, 255)), prio);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results and let the block idle before the verdict
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
